// ===== hdl/dwr_pkg.sv =====
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared types and constants for the draw-without-replacement unit.
// ----------------------------------------------------------------------------
package dwr_pkg;

    localparam int POOL_DEPTH_DEF = 256;
    localparam int RANGE_W        = 9;
    localparam int FRAC_W         = 32;
    localparam int OUT_W          = 8;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 9'd256;

    localparam logic OP_DRAW  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXTRACT
    } state_t;

    typedef struct packed
    {
        logic load;
        logic clear;
        logic extract;
    } dwr_cmd_t;

    typedef struct packed
    {
        logic draw_empty;
    } dwr_status_t;

endpackage

// ===== hdl/draw_without_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// draw_without_replacement_unit
// Deals 0 .. range_size-1 (range saturated to POOL_DEPTH) in random order, each value once per round.
// ----------------------------------------------------------------------------
//  channel   handshake          word
//  command   start / busy       operation, random_fraction
//  result    done (strobe)      drawn_value, remaining
//  config    cfg_write          cfg_data (range_size)
//
//  a draw runs index scaling (9x32 multiply) then cell chain shift
//  a clear completes in the cycle it is accepted, busy stays low
//  result strobe follows the shift cycle; a new command is taken alongside it
//  reset clears the pool and sets range_size to 256; no clearing pass
//  the receiver cannot stall the result
// ----------------------------------------------------------------------------
module draw_without_replacement_unit
#(
    parameter int POOL_DEPTH = dwr_pkg::POOL_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [dwr_pkg::FRAC_W-1:0]    random_fraction,
    input  logic                          cfg_write,
    input  logic [dwr_pkg::RANGE_W-1:0]   cfg_data,
    output logic                          done,
    output logic [dwr_pkg::OUT_W-1:0]     drawn_value,
    output logic [dwr_pkg::OUT_W-1:0]     remaining
);

    dwr_pkg::dwr_cmd_t    cmd;
    dwr_pkg::dwr_status_t status;

    dwr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    dwr_datapath
    #(
        .POOL_DEPTH (POOL_DEPTH)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .random_fraction (random_fraction),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .done            (done),
        .drawn_value     (drawn_value),
        .remaining       (remaining)
    );

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding extract cycle");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("extract lasted more than one cycle");

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == dwr_pkg::OP_CLEAR)) |=> !done)
        else $error("clear produced a result");
`endif

endmodule

// ===== hdl/dwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwr_ctrl
// Controller: accepts commands and sequences the pool datapath.
// ----------------------------------------------------------------------------
module dwr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               operation,
    input  dwr_pkg::dwr_status_t status,
    output dwr_pkg::dwr_cmd_t  cmd,
    output logic               busy
);

    dwr_pkg::state_t state_reg;
    dwr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dwr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.clear   = 1'b0;
        cmd.extract = 1'b0;
        busy        = 1'b0;
        unique case (state_reg)
            dwr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == dwr_pkg::OP_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (!status.draw_empty)
                    begin
                        cmd.load   = 1'b1;
                        state_next = dwr_pkg::ST_EXTRACT;
                    end
                end
            end
            dwr_pkg::ST_EXTRACT:
            begin
                busy        = 1'b1;
                cmd.extract = 1'b1;
                state_next  = dwr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dwr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/dwr_datapath.sv =====
// ----------------------------------------------------------------------------
// dwr_datapath
// Pool cell chain, count, range register, index scaling and result words.
// ----------------------------------------------------------------------------
module dwr_datapath
#(
    parameter int POOL_DEPTH = dwr_pkg::POOL_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dwr_pkg::dwr_cmd_t             cmd,
    output dwr_pkg::dwr_status_t          status,
    input  logic [dwr_pkg::FRAC_W-1:0]    random_fraction,
    input  logic                          cfg_write,
    input  logic [dwr_pkg::RANGE_W-1:0]   cfg_data,
    output logic                          done,
    output logic [dwr_pkg::OUT_W-1:0]     drawn_value,
    output logic [dwr_pkg::OUT_W-1:0]     remaining
);

    localparam int EW = $clog2(POOL_DEPTH);
    localparam int IW = EW;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int MW = (CW > dwr_pkg::RANGE_W) ? CW : dwr_pkg::RANGE_W;
    localparam int VW = (EW > dwr_pkg::OUT_W) ? EW : dwr_pkg::OUT_W;
    localparam int RW = (CW > dwr_pkg::OUT_W) ? CW : dwr_pkg::OUT_W;
    localparam int PW = CW + dwr_pkg::FRAC_W;

    logic [EW-1:0]                cell_reg [POOL_DEPTH];
    logic [dwr_pkg::RANGE_W-1:0]  range_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                pick_reg;
    logic                         done_reg;
    logic [VW-1:0]                value_reg;
    logic [RW-1:0]                remaining_reg;

    logic [MW-1:0]                range_ext;
    logic [MW-1:0]                depth_ext;
    logic [MW-1:0]                range_sat;
    logic [CW-1:0]                refill_n;
    logic [CW-1:0]                eff_count;
    logic [PW-1:0]                product;
    logic [CW-1:0]                idx_clamped;
    logic [IW-1:0]                idx;
    logic                         refill;

    // refill size saturated to the pool depth
    assign range_ext = MW'(range_reg);
    assign depth_ext = MW'(POOL_DEPTH);
    assign range_sat = (range_ext > depth_ext) ? depth_ext : range_ext;
    assign refill_n  = range_sat[CW-1:0];

    assign refill    = (count_reg == '0);
    assign eff_count = refill ? refill_n : count_reg;
    assign status.draw_empty = (eff_count == '0);

    assign product = PW'(eff_count) * PW'(random_fraction);

    assign idx_clamped = (pick_reg >= count_reg) ? (count_reg - CW'(1)) : pick_reg;
    assign idx         = idx_clamped[IW-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (cfg_write || cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.load)
        begin
            count_next = eff_count;
        end
        else if (cmd.extract)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= dwr_pkg::RANGE_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                range_reg <= cfg_data;
            end
            count_reg <= count_next;
            done_reg  <= cmd.extract;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pick_reg <= product[PW-1:dwr_pkg::FRAC_W];
        end
        if (cmd.extract)
        begin
            value_reg     <= VW'(cell_reg[idx]);
            remaining_reg <= RW'(count_next);
        end
    end

    // cell chain: refill loads own index, extract closes the gap
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            if (cmd.load && refill)
            begin
                cell_reg[i] <= EW'(i);
            end
            else if (cmd.extract && (IW'(i) >= idx) && (i < POOL_DEPTH - 1))
            begin
                cell_reg[i] <= cell_reg[(i + 1) % POOL_DEPTH];
            end
        end
    end

    assign done        = done_reg;
    assign drawn_value = value_reg[dwr_pkg::OUT_W-1:0];
    assign remaining   = remaining_reg[dwr_pkg::OUT_W-1:0];

endmodule

// ===== bench/tb_draw_without_replacement_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_draw_without_replacement_unit
// Self-checking bench for the draw-without-replacement unit. A scoreboard
// keeps its own ordered pool, predicts every drawn value and pool count, and
// checks each strobed result against the oldest prediction. Directed words
// cover the fraction extremes, clears, refills, a zero range and ranges above
// the pool depth; random phases then sweep many range settings with bursts
// of idle cycles on the command side.
// ----------------------------------------------------------------------------

typedef struct {
    logic [dwr_pkg::OUT_W-1:0] value;
    logic [dwr_pkg::OUT_W-1:0] left;
} draw_t;

class draw_checker;
    bit [dwr_pkg::OUT_W-1:0]   pool [dwr_pkg::POOL_DEPTH_DEF];
    int unsigned               pool_count;
    logic [dwr_pkg::RANGE_W-1:0] range_size;
    draw_t                     expected_draws [$];
    int                        errors;
    int                        draws_checked;
    int                        clears;
    int                        pools_emptied;
    int                        settings;

    function new();
        range_size    = dwr_pkg::RANGE_RESET;
        pool_count    = 0;
        errors        = 0;
        draws_checked = 0;
        clears        = 0;
        pools_emptied = 0;
        settings      = 1;
    endfunction

    function void set_range(logic [dwr_pkg::RANGE_W-1:0] r);
        range_size = r;
        pool_count = 0;
        settings++;
    endfunction

    function int pending();
        return expected_draws.size();
    endfunction

    function void note_command(logic op, logic [dwr_pkg::FRAC_W-1:0] frac);
        int unsigned     fill;
        int unsigned     pick;
        longint unsigned product;
        draw_t           d;
        if (op == dwr_pkg::OP_CLEAR)
        begin
            pool_count = 0;
            clears++;
            return;
        end
        // empty pool: refill in ascending order, range saturated to depth
        if (pool_count == 0)
        begin
            fill = (range_size > dwr_pkg::POOL_DEPTH_DEF) ? dwr_pkg::POOL_DEPTH_DEF
                                                          : range_size;
            for (int i = 0; i < fill; i++)
                pool[i] = i[dwr_pkg::OUT_W-1:0];
            pool_count = fill;
        end
        if (pool_count == 0)
            return;
        product = 64'(pool_count) * 64'(frac);
        pick    = 32'(product >> 32);
        if (pick >= pool_count)
            pick = pool_count - 1;
        d.value = pool[pick];
        for (int unsigned i = pick; i + 1 < pool_count; i++)
            pool[i] = pool[i + 1];
        pool_count--;
        d.left = pool_count[dwr_pkg::OUT_W-1:0];
        expected_draws.insert(expected_draws.size(), d);
    endfunction

    function void check_draw(logic [dwr_pkg::OUT_W-1:0] value,
                             logic [dwr_pkg::OUT_W-1:0] left);
        draw_t e;
        if (expected_draws.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, actual drawn_value %0d remaining %0d",
                     $time, value, left);
            return;
        end
        e = expected_draws.pop_front();
        draws_checked++;
        if (value !== e.value)
        begin
            errors++;
            $display("%0t: drawn_value expected %0d actual %0d", $time, e.value, value);
        end
        if (left !== e.left)
        begin
            errors++;
            $display("%0t: remaining expected %0d actual %0d", $time, e.left, left);
        end
        if (e.left == 0)
            pools_emptied++;
    endfunction
endclass

module tb_draw_without_replacement_unit;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           operation;
    logic [dwr_pkg::FRAC_W-1:0]     random_fraction;
    logic                           cfg_write;
    logic [dwr_pkg::RANGE_W-1:0]    cfg_data;
    logic                           done;
    logic [dwr_pkg::OUT_W-1:0]      drawn_value;
    logic [dwr_pkg::OUT_W-1:0]      remaining;

    draw_checker         tracker;

    draw_without_replacement_unit dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .random_fraction (random_fraction),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .done            (done),
        .drawn_value     (drawn_value),
        .remaining       (remaining)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // results first: a word accepted alongside a result never owns it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_draw(drawn_value, remaining);
            if (start && !busy)
                tracker.note_command(operation, random_fraction);
        end
    end

    task automatic send_word(input logic op, input logic [dwr_pkg::FRAC_W-1:0] frac);
        begin
            start           <= 1'b1;
            operation       <= op;
            random_fraction <= frac;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic idle_gap(input int cycles);
        begin
            start           <= 1'b0;
            operation       <= 1'($urandom);
            random_fraction <= $urandom;
            repeat (cycles)
                @(negedge clk);
        end
    endtask

    task automatic write_range(input logic [dwr_pkg::RANGE_W-1:0] r);
        begin
            start <= 1'b0;
            @(negedge clk);
            while (tracker.pending() != 0 || busy)
                @(negedge clk);
            // a draw with nothing to deal may still be in flight
            repeat (4)
                @(negedge clk);
            while (busy)
                @(negedge clk);
            cfg_write <= 1'b1;
            cfg_data  <= r;
            @(negedge clk);
            cfg_write <= 1'b0;
            tracker.set_range(r);
        end
    endtask

    function automatic logic [dwr_pkg::FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return dwr_pkg::FRAC_W'($urandom_range(0, 255));
            3:       return '1 - dwr_pkg::FRAC_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [dwr_pkg::RANGE_W-1:0] pick_range();
        case ($urandom_range(0, 9))
            0:       return 9'd1;
            1:       return 9'd2;
            2:       return 9'($urandom_range(3, 16));
            3:       return 9'($urandom_range(17, 255));
            4:       return 9'd256;
            5:       return 9'($urandom_range(257, 511));
            6:       return 9'd511;
            default: return 9'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic drive_random(input int idle_pct);
        logic op;
        begin
            op = ($urandom_range(0, 99) < 4) ? dwr_pkg::OP_CLEAR : dwr_pkg::OP_DRAW;
            if ($urandom_range(0, 99) < idle_pct)
                idle_gap($urandom_range(1, 17));
            send_word(op, pick_fraction());
        end
    endtask

    initial
    begin
        int  items;
        int  n;
        int  idle_pct;
        int  wait_cycles;
        bit  zero_done;
        tracker         = new();
        rst_n           = 1'b0;
        start           = 1'b0;
        operation       = dwr_pkg::OP_DRAW;
        random_fraction = '0;
        cfg_write       = 1'b0;
        cfg_data        = '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset range, fraction extremes, clear and refill
        send_word(dwr_pkg::OP_DRAW, '0);
        send_word(dwr_pkg::OP_DRAW, '1);
        send_word(dwr_pkg::OP_DRAW, 32'h8000_0000);
        send_word(dwr_pkg::OP_CLEAR, $urandom);
        send_word(dwr_pkg::OP_DRAW, '1);
        // single value rounds at both fraction extremes
        write_range(9'd1);
        send_word(dwr_pkg::OP_DRAW, '1);
        send_word(dwr_pkg::OP_DRAW, '0);
        // zero range deals nothing
        write_range(9'd0);
        send_word(dwr_pkg::OP_DRAW, $urandom);
        send_word(dwr_pkg::OP_CLEAR, $urandom);
        send_word(dwr_pkg::OP_DRAW, '0);
        // ranges above the pool depth saturate
        write_range(9'd511);
        send_word(dwr_pkg::OP_DRAW, '1);
        write_range(9'd257);
        send_word(dwr_pkg::OP_DRAW, '0);
        write_range(9'd2);
        send_word(dwr_pkg::OP_DRAW, '1);
        send_word(dwr_pkg::OP_DRAW, '0);
        send_word(dwr_pkg::OP_DRAW, 32'h7FFF_FFFF);

        items     = 0;
        zero_done = 1'b0;
        while (items < 1600)
        begin
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (items >= 1350)
                idle_pct = 0;
            n = $urandom_range(30, 150);
            write_range(pick_range());
            repeat (n)
                drive_random(idle_pct);
            items += n;
            if (!zero_done && items > 700)
            begin
                zero_done = 1'b1;
                write_range(9'd0);
                repeat (6)
                    drive_random(idle_pct);
            end
        end

        start <= 1'b0;
        wait_cycles = 0;
        while (tracker.pending() != 0 && wait_cycles < 2000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (8)
            @(negedge clk);
        if (tracker.pending() != 0)
        begin
            tracker.errors++;
            $display("%0t: %0d draws expected but never delivered",
                     $time, tracker.pending());
        end

        $display("checked %0d draws over %0d range settings, %0d clears, %0d pools emptied",
                 tracker.draws_checked, tracker.settings, tracker.clears,
                 tracker.pools_emptied);
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
